FILE: hw/rtl/mafhd_pkg.sv
// Package for the MPEG audio frame header decoder: bitrate table, rate constants,
// reciprocals for the constant-rate divider and the structs passed between stages.
// No dependencies.
package mafhd_pkg;

  localparam int RECIP_SHIFT = 26;
  localparam int NUM_W       = 26;  // numerator width, max 144 * 448000 < 2**26
  localparam int RECIP_W     = 14;
  localparam int QUOT_W      = 12;
  localparam int REM_W       = 17;  // remainder stays below twice the largest rate

  localparam logic [18:0] KBPS_SCALE = 19'd1000;

  localparam logic [15:0] RATE_44100 = 16'd44100;
  localparam logic [15:0] RATE_48000 = 16'd48000;
  localparam logic [15:0] RATE_32000 = 16'd32000;
  localparam logic [15:0] RATE_22050 = 16'd22050;
  localparam logic [15:0] RATE_24000 = 16'd24000;
  localparam logic [15:0] RATE_16000 = 16'd16000;
  localparam logic [15:0] RATE_11025 = 16'd11025;
  localparam logic [15:0] RATE_12000 = 16'd12000;
  localparam logic [15:0] RATE_8000  = 16'd8000;

  localparam logic [RECIP_W-1:0] RECIP_44100 = RECIP_W'((1 << RECIP_SHIFT) / 44100);
  localparam logic [RECIP_W-1:0] RECIP_48000 = RECIP_W'((1 << RECIP_SHIFT) / 48000);
  localparam logic [RECIP_W-1:0] RECIP_32000 = RECIP_W'((1 << RECIP_SHIFT) / 32000);
  localparam logic [RECIP_W-1:0] RECIP_22050 = RECIP_W'((1 << RECIP_SHIFT) / 22050);
  localparam logic [RECIP_W-1:0] RECIP_24000 = RECIP_W'((1 << RECIP_SHIFT) / 24000);
  localparam logic [RECIP_W-1:0] RECIP_16000 = RECIP_W'((1 << RECIP_SHIFT) / 16000);
  localparam logic [RECIP_W-1:0] RECIP_11025 = RECIP_W'((1 << RECIP_SHIFT) / 11025);
  localparam logic [RECIP_W-1:0] RECIP_12000 = RECIP_W'((1 << RECIP_SHIFT) / 12000);
  localparam logic [RECIP_W-1:0] RECIP_8000  = RECIP_W'((1 << RECIP_SHIFT) / 8000);

  // Header field codes
  localparam logic [1:0] VER_MPEG25    = 2'd0;
  localparam logic [1:0] VER_RESERVED  = 2'd1;
  localparam logic [1:0] VER_MPEG2     = 2'd2;
  localparam logic [1:0] VER_MPEG1     = 2'd3;
  localparam logic [1:0] LAYER_RSVD    = 2'd0;
  localparam logic [1:0] LAYER_3       = 2'd1;
  localparam logic [1:0] LAYER_2       = 2'd2;
  localparam logic [1:0] LAYER_1       = 2'd3;
  localparam logic [1:0] FREQ_IDX_0    = 2'd0;
  localparam logic [1:0] FREQ_IDX_1    = 2'd1;
  localparam logic [1:0] FREQ_IDX_2    = 2'd2;
  localparam logic [1:0] FREQ_RESERVED = 2'd3;
  localparam logic [1:0] MODE_MONO     = 2'd3;

  // kbps by [MPEG-1 ? 0 : 1][layer code][bitrate index]; layer code 0 is reserved
  localparam logic [8:0] KBPS_TAB [0:1][0:3][0:15] = '{
    '{
      '{9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0,
        9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0},
      '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
      '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
        9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0}
    },
    '{
      '{9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0,
        9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0},
      '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
      '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0}
    }
  };

  // Result fields that ride alongside the division
  typedef struct packed {
    logic        header_valid;
    logic [10:0] samples_per_frame;
    logic [15:0] sample_rate_hz;
    logic [1:0]  channel_count;
    logic [2:0]  pad_bytes;
  } hdr_meta_t;

  typedef struct packed {
    hdr_meta_t          meta;
    logic [18:0]        bitrate_bps;
    logic [7:0]         samples_div8;
    logic [RECIP_W-1:0] recip;
  } dec_t;

  typedef struct packed {
    hdr_meta_t   meta;
    logic [11:0] frame_bytes;
  } result_t;

endpackage

FILE: hw/rtl/mafhd_decode.sv
// Decode stage of the MPEG audio frame header decoder: splits the header word,
// looks up bitrate, samples, rate and reciprocal, and registers them.
// Depends on mafhd_pkg.
module mafhd_decode (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [31:0]          header_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mafhd_pkg::dec_t      out_data
);
  import mafhd_pkg::*;

  logic [1:0] ver;
  logic [1:0] lay;
  logic [3:0] bri;
  logic [1:0] fri;
  logic       pad;
  logic [1:0] mode;
  logic       vi;
  logic       ok;
  logic [8:0] kbps;
  dec_t       dec_next;
  logic [15:0] rate;
  logic [RECIP_W-1:0] recip;
  logic [10:0] samples;

  assign ver  = header_word[20:19];
  assign lay  = header_word[18:17];
  assign bri  = header_word[15:12];
  assign fri  = header_word[11:10];
  assign pad  = header_word[9];
  assign mode = header_word[7:6];
  assign vi   = (ver != VER_MPEG1);
  assign ok   = (ver != VER_RESERVED) && (lay != LAYER_RSVD) && (fri != FREQ_RESERVED);
  assign kbps = KBPS_TAB[vi][lay][bri];

  always_comb begin
    unique case ({ver, fri})
      {VER_MPEG1, FREQ_IDX_0}:  begin rate = RATE_44100; recip = RECIP_44100; end
      {VER_MPEG1, FREQ_IDX_1}:  begin rate = RATE_48000; recip = RECIP_48000; end
      {VER_MPEG1, FREQ_IDX_2}:  begin rate = RATE_32000; recip = RECIP_32000; end
      {VER_MPEG2, FREQ_IDX_0}:  begin rate = RATE_22050; recip = RECIP_22050; end
      {VER_MPEG2, FREQ_IDX_1}:  begin rate = RATE_24000; recip = RECIP_24000; end
      {VER_MPEG2, FREQ_IDX_2}:  begin rate = RATE_16000; recip = RECIP_16000; end
      {VER_MPEG25, FREQ_IDX_0}: begin rate = RATE_11025; recip = RECIP_11025; end
      {VER_MPEG25, FREQ_IDX_1}: begin rate = RATE_12000; recip = RECIP_12000; end
      {VER_MPEG25, FREQ_IDX_2}: begin rate = RATE_8000;  recip = RECIP_8000;  end
      default:                  begin rate = 16'd0;      recip = RECIP_44100; end
    endcase
  end

  always_comb begin
    unique case (lay)
      LAYER_1: samples = 11'd384;
      LAYER_2: samples = 11'd1152;
      LAYER_3: samples = vi ? 11'd576 : 11'd1152;
      default: samples = 11'd0;
    endcase
  end

  always_comb begin
    dec_next.meta.header_valid      = ok;
    dec_next.meta.samples_per_frame = ok ? samples : 11'd0;
    dec_next.meta.sample_rate_hz    = ok ? rate : 16'd0;
    dec_next.meta.channel_count     = (mode == MODE_MONO) ? 2'd1 : 2'd2;
    dec_next.meta.pad_bytes         = !pad ? 3'd0 : ((lay == LAYER_1) ? 3'd4 : 3'd1);
    // invalid headers divide zero; the final stage forces their length anyway
    dec_next.bitrate_bps            = ok ? (19'(kbps) * KBPS_SCALE) : 19'd0;
    dec_next.samples_div8           = ok ? samples[10:3] : 8'd0;
    dec_next.recip                  = recip;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= dec_next;
    end
  end

endmodule

FILE: hw/rtl/mafhd_divide.sv
// Pipelined divider by one of nine fixed sample rates for the frame header decoder:
// numerator product, reciprocal multiply, remainder, correction and padding.
// Depends on mafhd_pkg.
module mafhd_divide (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mafhd_pkg::dec_t      in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mafhd_pkg::result_t   out_data
);
  import mafhd_pkg::*;

  // stage a: numerator
  logic               va;
  hdr_meta_t          meta_a;
  logic [NUM_W-1:0]   num_a;
  logic [RECIP_W-1:0] recip_a;
  // stage b: quotient estimate, low by at most one
  logic               vb;
  hdr_meta_t          meta_b;
  logic [NUM_W-1:0]   num_b;
  logic [QUOT_W-1:0]  quot_b;
  // stage c: remainder
  logic               vc;
  hdr_meta_t          meta_c;
  logic [QUOT_W-1:0]  quot_c;
  logic [REM_W-1:0]   rem_c;

  logic adv_a;
  logic adv_b;
  logic adv_c;
  logic adv_o;

  logic [NUM_W+RECIP_W-1:0] est_prod;
  logic [NUM_W+1:0]         back_prod;
  logic [NUM_W-1:0]         rem_full;
  logic                     corr;
  logic [11:0]              bytes_next;

  assign adv_o    = !out_valid || out_ready;
  assign adv_c    = !vc || adv_o;
  assign adv_b    = !vb || adv_c;
  assign adv_a    = !va || adv_b;
  assign in_ready = adv_a;

  assign est_prod  = (NUM_W+RECIP_W)'(num_a) * (NUM_W+RECIP_W)'(recip_a);
  assign back_prod = (NUM_W+2)'(quot_b) * (NUM_W+2)'(meta_b.sample_rate_hz);
  assign rem_full  = num_b - back_prod[NUM_W-1:0];
  assign corr      = (rem_c >= REM_W'(meta_c.sample_rate_hz));
  assign bytes_next = !meta_c.header_valid ? 12'd1 :
                      (quot_c + 12'(corr) + 12'(meta_c.pad_bytes));

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv_a) va <= in_valid;
      if (adv_b) vb <= va;
      if (adv_c) vc <= vb;
      if (adv_o) out_valid <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a && in_valid) begin
      meta_a  <= in_data.meta;
      num_a   <= NUM_W'(in_data.samples_div8) * NUM_W'(in_data.bitrate_bps);
      recip_a <= in_data.recip;
    end
    if (adv_b && va) begin
      meta_b <= meta_a;
      num_b  <= num_a;
      quot_b <= est_prod[RECIP_SHIFT +: QUOT_W];
    end
    if (adv_c && vb) begin
      meta_c <= meta_b;
      quot_c <= quot_b;
      rem_c  <= rem_full[REM_W-1:0];
    end
    if (adv_o && vc) begin
      out_data.meta        <= meta_c;
      out_data.frame_bytes <= bytes_next;
    end
  end

endmodule

FILE: hw/rtl/mpeg_audio_frame_header_decode_unit.sv
// MPEG audio frame header decoder, top level: one header word in per request, one
// result out. Five register stages; one header per cycle while the output side
// accepts. Depends on mafhd_pkg, mafhd_decode and mafhd_divide.
//
// Each request carries one 32-bit frame header (big-endian byte order) and gives one
// result: valid flag, frame length in bytes, samples per frame, sample rate and channel
// count. Headers are independent, so a new one is taken every cycle while the output
// side accepts; the stages are decode, numerator multiply, reciprocal multiply,
// remainder, and correction and padding. The frame length divides by the sample rate
// through a fixed reciprocal and one correction step. Each stage holds its item under
// backpressure and bubbles fill up, so a stalled output still lets the pipe take input
// until it is full. A reserved version, layer or rate index gives valid 0, length 1,
// samples 0 and rate 0; bitrate index 0 or 15 gives a length of only the padding.
module mpeg_audio_frame_header_decode_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] header_word
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // [0] header_valid, [12:1] frame_bytes,
                                      // [23:13] samples_per_frame,
                                      // [39:24] sample_rate_hz, [41:40] channel_count,
                                      // [47:42] zero
);
  import mafhd_pkg::*;

  logic    dec_valid;
  logic    dec_ready;
  dec_t    dec_data;
  result_t res;

  mafhd_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .header_word(s_axis_tdata),
    .out_valid  (dec_valid),
    .out_ready  (dec_ready),
    .out_data   (dec_data)
  );

  mafhd_divide u_divide (
    .clk      (clk),
    .rst      (rst),
    .in_valid (dec_valid),
    .in_ready (dec_ready),
    .in_data  (dec_data),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data (res)
  );

  assign m_axis_tdata = {6'd0,
                         res.meta.channel_count,
                         res.meta.sample_rate_hz,
                         res.meta.samples_per_frame,
                         res.frame_bytes,
                         res.meta.header_valid};

endmodule

FILE: tb/tb_mpeg_audio_frame_header_decode_unit.sv
// Self-checking testbench for mpeg_audio_frame_header_decode_unit: directed and random
// header words, random idling on both stream sides, results checked in order.
// Depends on mafhd_pkg and the decoder RTL.
`timescale 1ns / 100ps

module tb_mpeg_audio_frame_header_decode_unit;
  import mafhd_pkg::*;

  localparam int RANDOM_HEADERS = 1700;
  localparam int CALM_TAIL      = 250;     // last requests go without idling
  localparam int CYCLE_LIMIT    = 400000;

  // kbps per layer code (1 = Layer 3, 2 = Layer 2, 3 = Layer 1)
  localparam int KBPS_MPEG1 [1:3][16] = '{
    '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0},
    '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
    '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0}
  };
  // MPEG 2 and 2.5 share these
  localparam int KBPS_LSF_L1 [16] =
    '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0};
  localparam int KBPS_LSF_L23 [16] =
    '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0};

  typedef struct packed {
    logic        header_valid;
    logic [11:0] frame_bytes;
    logic [10:0] samples_per_frame;
    logic [15:0] sample_rate_hz;
    logic [1:0]  channel_count;
  } frame_info_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  logic [31:0]  header_queue [$];
  frame_info_t  frames_expected [$];
  int           headers_taken = 0;
  int           frames_seen = 0;
  int           error_count = 0;
  int           cycle_count = 0;
  int           send_gap = 0;
  int           recv_gap = 0;
  int           pause_early = 0;
  int           pause_mid = 0;
  bit           in_took = 1'b0;

  mpeg_audio_frame_header_decode_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk = ~clk;

  function automatic frame_info_t decode_header(input logic [31:0] w);
    frame_info_t f;
    logic [1:0]  ver;
    logic [1:0]  lay;
    logic [1:0]  fri;
    logic [3:0]  bri;
    int          kbps;
    int          samples;
    int          rate;
    int          nbytes;
    ver = w[20:19];
    lay = w[18:17];
    bri = w[15:12];
    fri = w[11:10];
    f.channel_count = (w[7:6] == MODE_MONO) ? 2'd1 : 2'd2;
    if (ver == VER_RESERVED || lay == LAYER_RSVD || fri == FREQ_RESERVED) begin
      f.header_valid      = 1'b0;
      f.frame_bytes       = 12'd1;
      f.samples_per_frame = '0;
      f.sample_rate_hz    = '0;
      return f;
    end
    if (ver == VER_MPEG1) begin
      kbps    = KBPS_MPEG1[lay][bri];
      samples = (lay == LAYER_1) ? 384 : 1152;
      case (fri)
        FREQ_IDX_0: rate = int'(RATE_44100);
        FREQ_IDX_1: rate = int'(RATE_48000);
        default:    rate = int'(RATE_32000);
      endcase
    end else begin
      kbps    = (lay == LAYER_1) ? KBPS_LSF_L1[bri] : KBPS_LSF_L23[bri];
      samples = (lay == LAYER_1) ? 384 : (lay == LAYER_2) ? 1152 : 576;
      case (fri)
        FREQ_IDX_0: rate = int'(RATE_22050);
        FREQ_IDX_1: rate = int'(RATE_24000);
        default:    rate = int'(RATE_16000);
      endcase
      if (ver == VER_MPEG25) rate = rate / 2;
    end
    nbytes = ((samples / 8) * (1000 * kbps)) / rate;
    if (w[9]) nbytes += (lay == LAYER_1) ? 4 : 1;
    f.header_valid      = 1'b1;
    f.frame_bytes       = nbytes[11:0];
    f.samples_per_frame = samples[10:0];
    f.sample_rate_hz    = rate[15:0];
    return f;
  endfunction

  // remaining header bits are random
  function automatic logic [31:0] pack_header(input logic [1:0] ver, input logic [1:0] lay,
                                              input logic [3:0] bri, input logic [1:0] fri,
                                              input logic pad, input logic [1:0] mode);
    logic [31:0] w;
    w = $urandom;
    w[20:19] = ver;
    w[18:17] = lay;
    w[15:12] = bri;
    w[11:10] = fri;
    w[9]     = pad;
    w[7:6]   = mode;
    return w;
  endfunction

  // input side: one request per cycle while the DUT is ready, unless idling or holding off
  always @(negedge clk) begin
    logic        v;
    logic [31:0] d;
    d = s_axis_tdata;
    v = 1'b0;
    if (rst) begin
      v = 1'b0;
    end else if (s_axis_tvalid && !in_took) begin
      v = 1'b1;
    end else if (send_gap > 0) begin
      send_gap--;
    end else if ((headers_taken == pause_early || headers_taken == pause_mid) &&
                 frames_expected.size() != 0) begin
      v = 1'b0;  // let the pipe drain completely
    end else if (header_queue.size() > 0) begin
      d = header_queue.pop_front();
      v = 1'b1;
      if (header_queue.size() > CALM_TAIL && (headers_taken / 128) % 2 == 0 &&
          $urandom_range(0, 5) == 0)
        send_gap = $urandom_range(1, 17);
    end
    s_axis_tvalid <= v;
    s_axis_tdata  <= d;
  end

  // output side stalls
  always @(negedge clk) begin
    logic r;
    r = 1'b1;
    if (rst) begin
      r = 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      r = 1'b0;
    end else if (header_queue.size() > CALM_TAIL && (frames_seen / 96) % 3 != 0 &&
                 $urandom_range(0, 5) == 0) begin
      recv_gap = $urandom_range(0, 16);
      r = 1'b0;
    end
    m_axis_tready <= r;
  end

  always @(posedge clk) begin
    frame_info_t exp_f;
    frame_info_t got;
    in_took = !rst && s_axis_tvalid && s_axis_tready;
    if (in_took) begin
      frames_expected.push_back(decode_header(s_axis_tdata));
      headers_taken++;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      frames_seen++;
      got.header_valid      = m_axis_tdata[0];
      got.frame_bytes       = m_axis_tdata[12:1];
      got.samples_per_frame = m_axis_tdata[23:13];
      got.sample_rate_hz    = m_axis_tdata[39:24];
      got.channel_count     = m_axis_tdata[41:40];
      if (frames_expected.size() == 0) begin
        $error("unexpected result %h", m_axis_tdata);
        error_count++;
      end else begin
        exp_f = frames_expected.pop_front();
        if (got.header_valid !== exp_f.header_valid) begin
          $error("header_valid: expected %0d, got %0d", exp_f.header_valid,
                 got.header_valid);
          error_count++;
        end
        if (got.frame_bytes !== exp_f.frame_bytes) begin
          $error("frame_bytes: expected %0d, got %0d", exp_f.frame_bytes, got.frame_bytes);
          error_count++;
        end
        if (got.samples_per_frame !== exp_f.samples_per_frame) begin
          $error("samples_per_frame: expected %0d, got %0d", exp_f.samples_per_frame,
                 got.samples_per_frame);
          error_count++;
        end
        if (got.sample_rate_hz !== exp_f.sample_rate_hz) begin
          $error("sample_rate_hz: expected %0d, got %0d", exp_f.sample_rate_hz,
                 got.sample_rate_hz);
          error_count++;
        end
        if (got.channel_count !== exp_f.channel_count) begin
          $error("channel_count: expected %0d, got %0d", exp_f.channel_count,
                 got.channel_count);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_mpeg_audio_frame_header_decode_unit failed");
      $finish;
    end
  end

  initial begin
    logic [1:0] ver;
    logic [1:0] lay;
    int         pick;
    // directed headers
    header_queue.push_back(32'h0000_0000);   // MPEG 2.5 with reserved layer
    header_queue.push_back(32'hFFFF_FFFF);   // reserved rate index, all ones
    header_queue.push_back(pack_header(VER_RESERVED, LAYER_3, 4'd9, FREQ_IDX_0, 1'b1,
                                       MODE_MONO));
    header_queue.push_back(pack_header(VER_MPEG1, LAYER_RSVD, 4'd9, FREQ_IDX_1, 1'b0, 2'd0));
    header_queue.push_back(pack_header(VER_MPEG2, LAYER_2, 4'd5, FREQ_RESERVED, 1'b1, 2'd1));
    // free format and bad bitrate: padding only
    header_queue.push_back(pack_header(VER_MPEG1, LAYER_1, 4'd0, FREQ_IDX_0, 1'b1, 2'd2));
    header_queue.push_back(pack_header(VER_MPEG2, LAYER_2, 4'd15, FREQ_IDX_1, 1'b1,
                                       MODE_MONO));
    header_queue.push_back(pack_header(VER_MPEG25, LAYER_3, 4'd0, FREQ_IDX_2, 1'b0, 2'd0));
    // longest frame
    header_queue.push_back(pack_header(VER_MPEG25, LAYER_2, 4'd14, FREQ_IDX_2, 1'b1, 2'd1));
    header_queue.push_back(pack_header(VER_MPEG1, LAYER_1, 4'd14, FREQ_IDX_2, 1'b1,
                                       MODE_MONO));
    header_queue.push_back(pack_header(VER_MPEG1, LAYER_3, 4'd1, FREQ_IDX_1, 1'b0, 2'd2));
    header_queue.push_back(pack_header(VER_MPEG2, LAYER_3, 4'd8, FREQ_IDX_0, 1'b1, 2'd0));
    foreach (KBPS_MPEG1[l]) begin
      header_queue.push_back(pack_header(VER_MPEG25, l[1:0], 4'($urandom_range(1, 14)),
                                         2'($urandom_range(0, 2)), 1'($urandom),
                                         2'($urandom)));
      header_queue.push_back(pack_header(VER_MPEG2, l[1:0], 4'($urandom_range(1, 14)),
                                         2'($urandom_range(0, 2)), 1'($urandom),
                                         2'($urandom)));
      header_queue.push_back(pack_header(VER_MPEG1, l[1:0], 4'($urandom_range(1, 14)),
                                         2'($urandom_range(0, 2)), 1'($urandom),
                                         2'($urandom)));
    end
    pause_early = header_queue.size();
    pause_mid   = pause_early + RANDOM_HEADERS / 2;
    // mostly usable headers, the rest raw words
    repeat (RANDOM_HEADERS) begin
      pick = $urandom_range(0, 3);
      if (pick == 0) begin
        header_queue.push_back($urandom);
      end else begin
        case ($urandom_range(0, 2))
          0:       ver = VER_MPEG25;
          1:       ver = VER_MPEG2;
          default: ver = VER_MPEG1;
        endcase
        lay = 2'($urandom_range(1, 3));
        header_queue.push_back(pack_header(ver, lay, 4'($urandom_range(0, 15)),
                                           2'($urandom_range(0, 2)), 1'($urandom),
                                           2'($urandom)));
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (header_queue.size() != 0 || s_axis_tvalid || frames_expected.size() != 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
    if (error_count == 0 && frames_expected.size() == 0)
      $display("tb_mpeg_audio_frame_header_decode_unit passed");
    else
      $display("tb_mpeg_audio_frame_header_decode_unit failed");
    $finish;
  end

endmodule
